// File: rtl/dgvd_pkg.sv
// ----------------------------------------------------------------------------
// dgvd_pkg
// Shared types and codes of the 2D DG volume-term block: command and result
// beats, opcodes, register indexes and the per-node control word.
// ----------------------------------------------------------------------------
package dgvd_pkg;

	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [2:0] OP_LOAD_DR = 3'd0;
	localparam logic [2:0] OP_LOAD_DS = 3'd1;
	localparam logic [2:0] OP_LOAD_AUX = 3'd2;
	localparam logic [2:0] OP_LOAD_GEOM = 3'd3;
	localparam logic [2:0] OP_COMPUTE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_NODES_IN_USE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELDS_IN_USE = 8'd1;

	localparam logic [4:0] NODES_RESET = 5'd16;
	localparam logic [2:0] FIELDS_RESET = 3'd4;

	typedef struct packed {
		logic [2:0] opcode;
		logic [3:0] node_index;
		logic [3:0] column_index;
		logic [1:0] field_index;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
		logic signed [31:0] value_c;
		logic signed [31:0] value_d;
	} cmd_t;

	typedef struct packed {
		logic [3:0] out_node;
		logic [1:0] out_field;
		logic signed [31:0] new_rhs;
		logic saturated;
	} result_t;

	// control that travels with one node term down the datapath
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} beat_ctl_t;

endpackage

// File: rtl/dg_volume_divergence_term.sv
// ----------------------------------------------------------------------------
// dg_volume_divergence_term
// Nodal DG volume term for one 2D element in Q16.16: load beats fill the
// Dr/Ds matrices, aux values and geometric factors; a compute beat returns
// old rhs plus the sum over nodes of dx*px + dy*py, saturated.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload        Notes
//  command   start / busy         cmd (cmd_t)    taken when start & !busy
//  result    done (strobe)        result         one cycle, no backpressure
//  config    cfg_valid/cfg_ready  cfg_index/data ready always high
//
//  A load beat does not raise busy. A compute beat keeps busy high while
//  one Dr entry, one Ds entry and one aux entry are read per cycle from the
//  memories for each node in use, then four datapath stages and the output
//  register drain. A compute beat whose node or field is out of range and
//  any unknown opcode give no result. Reset leaves the memories unwritten;
//  no clearing pass runs. The receiver cannot stall.
// ----------------------------------------------------------------------------
module dg_volume_divergence_term
	import dgvd_pkg::*;
#(
	parameter int MAX_NODES = 16,
	parameter int MAX_FIELDS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  cmd_t                  cmd,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
	localparam int AUX_DEPTH = MAX_NODES * MAX_FIELDS;
	localparam int MAT_AW = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
	localparam int AUX_AW = (AUX_DEPTH > 1) ? $clog2(AUX_DEPTH) : 1;
	localparam int GEOM_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam int FCNT_W = $clog2(MAX_FIELDS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	state_t state_q;
	logic [4:0] nodes_q;
	logic [2:0] fields_q;
	logic [CNT_W-1:0] np, m_q;
	logic [FCNT_W-1:0] nf;
	logic [3:0] node_q;
	logic [1:0] fld_q;
	logic signed [31:0] old_q;
	beat_ctl_t ctl_s1;

	logic accept, node_ok, col_ok, fld_ok, cmp_ok;
	logic we_dr, we_ds, we_aux, we_geom, re_geom, re_run;
	logic [MAT_AW-1:0] mat_waddr, mat_raddr;
	logic [AUX_AW-1:0] aux_waddr, aux_raddr;
	logic [GEOM_AW-1:0] geom_addr;
	logic [31:0] dr_rd, ds_rd;
	logic [63:0] aux_rd;
	logic [127:0] geom_rd;
	logic dp_done, dp_sat;
	logic signed [31:0] dp_rhs;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q <= NODES_RESET;
			fields_q <= FIELDS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NODES_IN_USE: nodes_q <= cfg_data[4:0];
				CFG_FIELDS_IN_USE: fields_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// clamp the registers into their usable range
	always_comb begin
		if (nodes_q == '0) begin
			np = CNT_W'(1);
		end else if (32'(nodes_q) > MAX_NODES) begin
			np = CNT_W'(MAX_NODES);
		end else begin
			np = CNT_W'(nodes_q);
		end
		if (fields_q == '0) begin
			nf = FCNT_W'(1);
		end else if (32'(fields_q) > MAX_FIELDS) begin
			nf = FCNT_W'(MAX_FIELDS);
		end else begin
			nf = FCNT_W'(fields_q);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign accept = start & ~busy;
	assign node_ok = 32'(cmd.node_index) < MAX_NODES;
	assign col_ok = 32'(cmd.column_index) < MAX_NODES;
	assign fld_ok = 32'(cmd.field_index) < MAX_FIELDS;
	assign cmp_ok = (32'(cmd.node_index) < 32'(np)) && (32'(cmd.field_index) < 32'(nf));

	assign we_dr = accept && (cmd.opcode == OP_LOAD_DR) && node_ok && col_ok;
	assign we_ds = accept && (cmd.opcode == OP_LOAD_DS) && node_ok && col_ok;
	assign we_aux = accept && (cmd.opcode == OP_LOAD_AUX) && node_ok && fld_ok;
	assign we_geom = accept && (cmd.opcode == OP_LOAD_GEOM) && node_ok;
	assign re_geom = accept && (cmd.opcode == OP_COMPUTE) && cmp_ok;
	assign re_run = (state_q == ST_RUN);

	assign mat_waddr = MAT_AW'(32'(cmd.node_index) * MAX_NODES + 32'(cmd.column_index));
	assign aux_waddr = AUX_AW'(32'(cmd.node_index) * MAX_FIELDS + 32'(cmd.field_index));
	assign geom_addr = GEOM_AW'(cmd.node_index);
	assign mat_raddr = MAT_AW'(32'(node_q) * MAX_NODES + 32'(m_q));
	assign aux_raddr = AUX_AW'(32'(m_q) * MAX_FIELDS + 32'(fld_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_q <= '0;
			node_q <= '0;
			fld_q <= '0;
			old_q <= '0;
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= '0;
			case (state_q)
				ST_IDLE: begin
					if (re_geom) begin
						node_q <= cmd.node_index;
						fld_q <= cmd.field_index;
						old_q <= cmd.value_a;
						m_q <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// issue one node per cycle; data lands with ctl_s1
					ctl_s1.valid <= 1'b1;
					ctl_s1.first <= (m_q == '0);
					ctl_s1.last <= (m_q == np - CNT_W'(1));
					m_q <= m_q + CNT_W'(1);
					if (m_q == np - CNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (dp_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	dgvd_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_dr_ram (
		.clk(clk), .we(we_dr), .waddr(mat_waddr), .wdata(cmd.value_a),
		.re(re_run), .raddr(mat_raddr), .rdata(dr_rd)
	);

	dgvd_ram #(.WIDTH(32), .DEPTH(MAT_DEPTH)) u_ds_ram (
		.clk(clk), .we(we_ds), .waddr(mat_waddr), .wdata(cmd.value_a),
		.re(re_run), .raddr(mat_raddr), .rdata(ds_rd)
	);

	dgvd_ram #(.WIDTH(64), .DEPTH(AUX_DEPTH)) u_aux_ram (
		.clk(clk), .we(we_aux), .waddr(aux_waddr),
		.wdata({cmd.value_b, cmd.value_a}),
		.re(re_run), .raddr(aux_raddr), .rdata(aux_rd)
	);

	// geometry: drdx, dsdx, drdy, dsdy from low to high
	dgvd_ram #(.WIDTH(128), .DEPTH(MAX_NODES)) u_geom_ram (
		.clk(clk), .we(we_geom), .waddr(geom_addr),
		.wdata({cmd.value_d, cmd.value_b, cmd.value_c, cmd.value_a}),
		.re(re_geom), .raddr(geom_addr), .rdata(geom_rd)
	);

	dgvd_datapath #(.MAX_NODES(MAX_NODES)) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl_s1),
		.geom(geom_rd),
		.dr(dr_rd),
		.ds(ds_rd),
		.aux(aux_rd),
		.old_rhs(old_q),
		.done(dp_done),
		.new_rhs(dp_rhs),
		.saturated(dp_sat)
	);

	assign done = dp_done;
	assign result = {node_q, fld_q, dp_rhs, dp_sat};

endmodule

// File: rtl/dgvd_ram.sv
// ----------------------------------------------------------------------------
// dgvd_ram
// Generic single-write, single-read synchronous RAM with registered read
// data. Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module dgvd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/dgvd_datapath.sv
// ----------------------------------------------------------------------------
// dgvd_datapath
// Per-node arithmetic: metric products, dx/dy saturation, flux products and
// the running sum, one node term a cycle, four stages deep.
// ----------------------------------------------------------------------------
module dgvd_datapath
	import dgvd_pkg::*;
#(
	parameter int MAX_NODES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  beat_ctl_t           ctl,
	input  logic [127:0]        geom,
	input  logic [31:0]         dr,
	input  logic [31:0]         ds,
	input  logic [63:0]         aux,
	input  logic signed [31:0]  old_rhs,
	output logic                done,
	output logic signed [31:0]  new_rhs,
	output logic                saturated
);

	localparam int ACC_W = 49 + $clog2(MAX_NODES + 1);
	localparam logic signed [48:0] TERM_HI = 49'sd2147483647;
	localparam logic signed [48:0] TERM_LO = -49'sd2147483648;
	localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(-64'sd2147483648);

	logic signed [31:0] drdx, dsdx, drdy, dsdy, dr_s, ds_s;

	assign drdx = $signed(geom[31:0]);
	assign dsdx = $signed(geom[63:32]);
	assign drdy = $signed(geom[95:64]);
	assign dsdy = $signed(geom[127:96]);
	assign dr_s = $signed(dr);
	assign ds_s = $signed(ds);

	// stage 2: metric products
	beat_ctl_t ctl_s2, ctl_s3, ctl_s4;
	logic signed [63:0] p_rx_s2, p_sx_s2, p_ry_s2, p_sy_s2;
	logic signed [31:0] px_s2, py_s2, px_s3, py_s3;

	// stage 3: saturated dx, dy
	logic signed [31:0] dx_s3, dy_s3;
	logic clip_s3, clip_s4;
	logic signed [48:0] sum_x, sum_y;
	logic signed [31:0] dx_n, dy_n;
	logic clip_n;

	// stage 4: flux products
	logic signed [63:0] tx_s4, ty_s4;

	// accumulate
	logic signed [48:0] term;
	logic signed [ACC_W-1:0] acc_q, acc_n;
	logic clip_acc_q, clip_acc_n;

	always_comb begin
		sum_x = 49'(p_rx_s2 >>> 16) + 49'(p_sx_s2 >>> 16);
		sum_y = 49'(p_ry_s2 >>> 16) + 49'(p_sy_s2 >>> 16);
		clip_n = 1'b0;
		if (sum_x > TERM_HI) begin
			dx_n = 32'sh7fffffff;
			clip_n = 1'b1;
		end else if (sum_x < TERM_LO) begin
			dx_n = 32'sh80000000;
			clip_n = 1'b1;
		end else begin
			dx_n = 32'(sum_x);
		end
		if (sum_y > TERM_HI) begin
			dy_n = 32'sh7fffffff;
			clip_n = 1'b1;
		end else if (sum_y < TERM_LO) begin
			dy_n = 32'sh80000000;
			clip_n = 1'b1;
		end else begin
			dy_n = 32'(sum_y);
		end
	end

	always_comb begin
		term = 49'(tx_s4 >>> 16) + 49'(ty_s4 >>> 16);
		if (ctl_s4.first) begin
			acc_n = ACC_W'(old_rhs) + ACC_W'(term);
			clip_acc_n = clip_s4;
		end else begin
			acc_n = acc_q + ACC_W'(term);
			clip_acc_n = clip_acc_q | clip_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			done <= 1'b0;
		end else begin
			ctl_s2 <= ctl;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			done <= ctl_s4.valid & ctl_s4.last;
		end
	end

	always_ff @(posedge clk) begin
		p_rx_s2 <= drdx * dr_s;
		p_sx_s2 <= dsdx * ds_s;
		p_ry_s2 <= drdy * dr_s;
		p_sy_s2 <= dsdy * ds_s;
		px_s2 <= $signed(aux[31:0]);
		py_s2 <= $signed(aux[63:32]);

		dx_s3 <= dx_n;
		dy_s3 <= dy_n;
		clip_s3 <= clip_n;
		px_s3 <= px_s2;
		py_s3 <= py_s2;

		tx_s4 <= dx_s3 * px_s3;
		ty_s4 <= dy_s3 * py_s3;
		clip_s4 <= clip_s3;

		if (ctl_s4.valid) begin
			acc_q <= acc_n;
			clip_acc_q <= clip_acc_n;
		end
		// saturate the final sum on the last node
		if (ctl_s4.valid && ctl_s4.last) begin
			if (acc_n > ACC_HI) begin
				new_rhs <= 32'sh7fffffff;
				saturated <= 1'b1;
			end else if (acc_n < ACC_LO) begin
				new_rhs <= 32'sh80000000;
				saturated <= 1'b1;
			end else begin
				new_rhs <= 32'(acc_n);
				saturated <= clip_acc_n;
			end
		end
	end

endmodule

// File: tb/dgvd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dgvd_checker
// Watches the command, config and result channels of the DG volume-term
// block, keeps its own copy of the matrices, aux values, geometric factors
// and registers, predicts each updated right-hand side and compares it with
// what the block returns.
// ----------------------------------------------------------------------------
module dgvd_checker
	import dgvd_pkg::*;
#(
	parameter int MAX_NODES = 16,
	parameter int MAX_FIELDS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  cmd_t                  cmd,
	input  logic                  done,
	input  result_t               result,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending,
	output int                    results_seen
);

	localparam longint Q_MAX = 2147483647;
	localparam longint Q_MIN = -Q_MAX - 1;

	logic signed [31:0] dr_mem [MAX_NODES*MAX_NODES];
	logic signed [31:0] ds_mem [MAX_NODES*MAX_NODES];
	logic signed [31:0] aux_x_mem [MAX_NODES*MAX_FIELDS];
	logic signed [31:0] aux_y_mem [MAX_NODES*MAX_FIELDS];
	logic signed [31:0] drdx_mem [MAX_NODES];
	logic signed [31:0] drdy_mem [MAX_NODES];
	logic signed [31:0] dsdx_mem [MAX_NODES];
	logic signed [31:0] dsdy_mem [MAX_NODES];
	logic [4:0] nodes_reg;
	logic [2:0] fields_reg;

	result_t rhs_expected [$];
	int err_cnt;
	int seen_cnt;

	// Q16.16 product, floor of the exact product shifted by 16
	function automatic longint qmul(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic longint clamp_q(longint v);
		if (v > Q_MAX)
			return Q_MAX;
		if (v < Q_MIN)
			return Q_MIN;
		return v;
	endfunction

	function automatic result_t rhs_update(cmd_t c, int np);
		result_t r;
		longint acc, dx, dy, dr, ds, px, py;
		longint drdx, dsdx, drdy, dsdy;
		logic clip;
		int row, m;
		row = int'(c.node_index) * MAX_NODES;
		drdx = drdx_mem[c.node_index];
		dsdx = dsdx_mem[c.node_index];
		drdy = drdy_mem[c.node_index];
		dsdy = dsdy_mem[c.node_index];
		clip = 1'b0;
		acc = longint'($signed(c.value_a));
		for (m = 0; m < np; m++) begin
			dr = dr_mem[row + m];
			ds = ds_mem[row + m];
			px = aux_x_mem[m * MAX_FIELDS + int'(c.field_index)];
			py = aux_y_mem[m * MAX_FIELDS + int'(c.field_index)];
			dx = qmul(drdx, dr) + qmul(dsdx, ds);
			dy = qmul(drdy, dr) + qmul(dsdy, ds);
			if (clamp_q(dx) != dx || clamp_q(dy) != dy)
				clip = 1'b1;
			dx = clamp_q(dx);
			dy = clamp_q(dy);
			acc += qmul(dx, px) + qmul(dy, py);
		end
		if (clamp_q(acc) != acc)
			clip = 1'b1;
		acc = clamp_q(acc);
		r.out_node = c.node_index;
		r.out_field = c.field_index;
		r.new_rhs = acc[31:0];
		r.saturated = clip;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int np, nf;
		result_t want;
		if (!arst_n) begin
			nodes_reg = NODES_RESET;
			fields_reg = FIELDS_RESET;
			rhs_expected.delete();
			err_cnt = 0;
			seen_cnt = 0;
			errors <= 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			// retire the result first: it belongs to an earlier compute beat
			if (done) begin
				seen_cnt++;
				if (rhs_expected.size() == 0) begin
					$display("%0t: result with nothing pending, expected none, got node %0d field %0d rhs %0d sat %0d",
						$time, result.out_node, result.out_field, $signed(result.new_rhs),
						result.saturated);
					err_cnt++;
				end else begin
					want = rhs_expected.pop_front();
					if (result.out_node !== want.out_node) begin
						$display("%0t: out_node mismatch, expected %0d, got %0d",
							$time, want.out_node, result.out_node);
						err_cnt++;
					end
					if (result.out_field !== want.out_field) begin
						$display("%0t: out_field mismatch, expected %0d, got %0d",
							$time, want.out_field, result.out_field);
						err_cnt++;
					end
					if (result.new_rhs !== want.new_rhs) begin
						$display("%0t: new_rhs mismatch, expected %0d, got %0d",
							$time, $signed(want.new_rhs), $signed(result.new_rhs));
						err_cnt++;
					end
					if (result.saturated !== want.saturated) begin
						$display("%0t: saturated mismatch, expected %0d, got %0d",
							$time, want.saturated, result.saturated);
						err_cnt++;
					end
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_NODES_IN_USE: nodes_reg = cfg_data[4:0];
					CFG_FIELDS_IN_USE: fields_reg = cfg_data[2:0];
					default: ;
				endcase
			end

			if (start && !busy) begin
				case (cmd.opcode)
					OP_LOAD_DR: begin
						dr_mem[int'(cmd.node_index) * MAX_NODES + int'(cmd.column_index)] =
							cmd.value_a;
					end
					OP_LOAD_DS: begin
						ds_mem[int'(cmd.node_index) * MAX_NODES + int'(cmd.column_index)] =
							cmd.value_a;
					end
					OP_LOAD_AUX: begin
						aux_x_mem[int'(cmd.node_index) * MAX_FIELDS + int'(cmd.field_index)] =
							cmd.value_a;
						aux_y_mem[int'(cmd.node_index) * MAX_FIELDS + int'(cmd.field_index)] =
							cmd.value_b;
					end
					OP_LOAD_GEOM: begin
						drdx_mem[cmd.node_index] = cmd.value_a;
						drdy_mem[cmd.node_index] = cmd.value_b;
						dsdx_mem[cmd.node_index] = cmd.value_c;
						dsdy_mem[cmd.node_index] = cmd.value_d;
					end
					OP_COMPUTE: begin
						np = (nodes_reg < 1) ? 1 : (nodes_reg > MAX_NODES) ? MAX_NODES : nodes_reg;
						nf = (fields_reg < 1) ? 1 :
							(fields_reg > MAX_FIELDS) ? MAX_FIELDS : fields_reg;
						// out-of-range node or field: dropped, no result
						if (cmd.node_index < np && cmd.field_index < nf)
							rhs_expected.push_back(rhs_update(cmd, np));
					end
					default: ;
				endcase
			end

			errors <= err_cnt;
			pending <= rhs_expected.size();
			results_seen <= seen_cnt;
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the DG volume-term block: a directed pass over index and value
// extremes, saturation and dropped beats, then random element loads with
// compute beats under several register settings, in bursts with random gaps.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import dgvd_pkg::*;

	localparam int MAX_NODES = 16;
	localparam int MAX_FIELDS = 4;
	localparam int RANDOM_BEATS = 500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cmd_t cmd = '0;
	logic done;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int errors, pending, results_seen;
	int beats_sent = 0;
	int settings_used = 0;
	int burst_left = 0;

	bit dr_written [MAX_NODES*MAX_NODES];
	bit ds_written [MAX_NODES*MAX_NODES];
	bit aux_written [MAX_NODES*MAX_FIELDS];
	bit geom_written [MAX_NODES];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	dg_volume_divergence_term #(
		.MAX_NODES(MAX_NODES),
		.MAX_FIELDS(MAX_FIELDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	dgvd_checker #(
		.MAX_NODES(MAX_NODES),
		.MAX_FIELDS(MAX_FIELDS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending),
		.results_seen(results_seen)
	);

	function automatic cmd_t mk(logic [31:0] op, logic [31:0] nd, logic [31:0] col,
			logic [31:0] fd, logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
		cmd_t x;
		x.opcode = op[2:0];
		x.node_index = nd[3:0];
		x.column_index = col[3:0];
		x.field_index = fd[1:0];
		x.value_a = a;
		x.value_b = b;
		x.value_c = c;
		x.value_d = d;
		return x;
	endfunction

	// Q16.16 operand: mostly small, some medium, some full range, some extremes
	function automatic logic [31:0] q_value();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel < 9)
			return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
		if (sel < 13)
			return $urandom_range(0, 32'h1ffffff) - 32'hffffff;
		if (sel < 16)
			return $urandom();
		case ($urandom_range(0, 5))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'h00000000;
			3: return 32'h00010000;
			4: return 32'hffff0000;
			default: return 32'hffffffff;
		endcase
	endfunction

	function automatic int eff_nodes(int raw);
		return (raw < 1) ? 1 : (raw > MAX_NODES) ? MAX_NODES : raw;
	endfunction

	function automatic int eff_fields(int raw);
		return (raw < 1) ? 1 : (raw > MAX_FIELDS) ? MAX_FIELDS : raw;
	endfunction

	// true when a compute on this node and field reads only written entries
	function automatic bit covered(int nd, int fd, int np);
		int m;
		if (!geom_written[nd])
			return 1'b0;
		for (m = 0; m < np; m++) begin
			if (!dr_written[nd * MAX_NODES + m] || !ds_written[nd * MAX_NODES + m] ||
					!aux_written[m * MAX_FIELDS + fd])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic send(input cmd_t c);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		burst_left--;
		beats_sent++;
		case (c.opcode)
			OP_LOAD_DR: dr_written[{c.node_index, c.column_index}] = 1'b1;
			OP_LOAD_DS: ds_written[{c.node_index, c.column_index}] = 1'b1;
			OP_LOAD_AUX: aux_written[{c.node_index, c.field_index}] = 1'b1;
			OP_LOAD_GEOM: geom_written[c.node_index] = 1'b1;
			default: ;
		endcase
	endtask

	// hold the command channel low until every result is back and the block settles
	task automatic drain();
		start <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	// hold valid; the caller drops it after the last beat
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_sizes(input int nodes_raw, input int fields_raw);
		write_reg(CFG_NODES_IN_USE, ($urandom() & 32'hffffffe0) | nodes_raw);
		write_reg(CFG_FIELDS_IN_USE, ($urandom() & 32'hfffffff8) | fields_raw);
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_FIELDS_IN_USE + 8'($urandom_range(1, 254)), $urandom());
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic unknown_op();
		send(mk(OP_COMPUTE + 3'($urandom_range(1, 3)), $urandom(), $urandom(), $urandom(),
			$urandom(), $urandom(), $urandom(), $urandom()));
	endtask

	// one element: load its rows and all aux values, then compute and stray beats
	task automatic run_element(input int np, input int nf);
		int rows [$];
		int n, col, m, f, pick, nd, fd;
		for (n = 0; n < np; n++) begin
			if (np <= 4 || $urandom_range(0, np - 1) < 2)
				rows.push_back(n);
		end
		if (rows.size() == 0)
			rows.push_back($urandom_range(0, np - 1));
		foreach (rows[i]) begin
			for (col = 0; col < np; col++) begin
				send(mk(OP_LOAD_DR, rows[i], col, $urandom(), q_value(), $urandom(),
					$urandom(), $urandom()));
				send(mk(OP_LOAD_DS, rows[i], col, $urandom(), q_value(), $urandom(),
					$urandom(), $urandom()));
			end
			send(mk(OP_LOAD_GEOM, rows[i], $urandom(), $urandom(), q_value(), q_value(),
				q_value(), q_value()));
		end
		for (m = 0; m < np; m++) begin
			for (f = 0; f < nf; f++)
				send(mk(OP_LOAD_AUX, m, $urandom(), f, q_value(), q_value(), $urandom(),
					$urandom()));
		end
		repeat ($urandom_range(2, 8)) begin
			pick = $urandom_range(0, 9);
			nd = rows[$urandom_range(0, rows.size() - 1)];
			fd = $urandom_range(0, nf - 1);
			if (pick == 6) begin
				// any node and field: dropped if out of range, else only if fully loaded
				nd = $urandom_range(0, MAX_NODES - 1);
				fd = $urandom_range(0, MAX_FIELDS - 1);
				if (nd >= np || fd >= nf || covered(nd, fd, np))
					send(mk(OP_COMPUTE, nd, $urandom(), fd, q_value(), $urandom(),
						$urandom(), $urandom()));
				else
					unknown_op();
			end else if (pick == 7) begin
				unknown_op();
			end else if (pick == 8) begin
				send(mk(3'($urandom_range(OP_LOAD_DR, OP_LOAD_GEOM)), $urandom(), $urandom(),
					$urandom(), q_value(), q_value(), q_value(), q_value()));
			end else begin
				send(mk(OP_COMPUTE, nd, $urandom(), fd, q_value(), $urandom(), $urandom(),
					$urandom()));
			end
		end
	endtask

	initial begin
		int phase, nodes_raw, fields_raw, directed_beats, sel;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one node, extremes of values, saturation, dropped beats
		set_sizes(1, 4);
		send(mk(OP_LOAD_DR, 0, 0, 3, 32'h00010000, 32'hffffffff, 0, 32'hffffffff));
		send(mk(OP_LOAD_DS, 0, 0, 0, 32'h7fffffff, 0, 32'hffffffff, 0));
		send(mk(OP_LOAD_GEOM, 0, 15, 3, 32'h00010000, 0, 0, 32'h00010000));
		send(mk(OP_LOAD_AUX, 0, 0, 0, 32'h00010000, 0, 0, 0));
		send(mk(OP_LOAD_AUX, 0, 15, 1, 32'h80000000, 32'hffffffff, 0, 0));
		send(mk(OP_LOAD_AUX, 0, 0, 2, 32'h7fffffff, 32'h7fffffff, 0, 0));
		send(mk(OP_LOAD_AUX, 0, 0, 3, 0, 32'h00010000, 0, 0));
		send(mk(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 0));
		send(mk(OP_COMPUTE, 0, 15, 1, 32'h80000000, 32'hffffffff, 32'hffffffff, 32'hffffffff));
		send(mk(OP_COMPUTE, 0, 0, 2, 32'h7fffffff, 0, 0, 0));
		send(mk(OP_COMPUTE, 0, 0, 3, 32'hffffffff, 0, 0, 0));
		send(mk(OP_COMPUTE, 1, 0, 0, 32'h00010000, 0, 0, 0));
		send(mk(3'd5, 15, 15, 3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
		send(mk(3'd6, 0, 0, 0, 0, 0, 0, 0));
		send(mk(3'd7, 7, 8, 2, $urandom(), $urandom(), $urandom(), $urandom()));
		// geometric factors at the extremes clip dx and dy
		send(mk(OP_LOAD_GEOM, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));
		send(mk(OP_COMPUTE, 0, 0, 0, 32'h12345678, 0, 0, 0));
		send(mk(OP_COMPUTE, 0, 0, 2, 32'h80000000, 0, 0, 0));
		send(mk(OP_LOAD_DR, 15, 15, 3, 32'hffffffff, 0, 0, 0));
		send(mk(OP_LOAD_DS, 15, 15, 3, 32'h80000000, 0, 0, 0));
		send(mk(OP_LOAD_AUX, 15, 15, 3, 32'h7fffffff, 32'h80000000, 0, 0));
		send(mk(OP_LOAD_GEOM, 15, 15, 3, 32'hffffffff, 32'hffffffff, 32'h80000000, 32'h7fffffff));
		drain();
		set_sizes(1, 2);
		send(mk(OP_COMPUTE, 0, 0, 3, 32'h00010000, 0, 0, 0));
		send(mk(OP_COMPUTE, 0, 0, 1, 32'hfffe0000, 0, 0, 0));
		directed_beats = beats_sent;

		// random: elements under changing sizes, extremes first
		phase = 0;
		while (beats_sent < directed_beats + RANDOM_BEATS) begin
			case (phase)
				0: begin nodes_raw = MAX_NODES; fields_raw = MAX_FIELDS; end
				1: begin nodes_raw = 0; fields_raw = 0; end
				2: begin nodes_raw = 31; fields_raw = 7; end
				default: begin
					sel = $urandom_range(0, 9);
					if (sel < 7)
						nodes_raw = $urandom_range(1, 4);
					else if (sel == 7)
						nodes_raw = $urandom_range(5, 15);
					else if (sel == 8)
						nodes_raw = MAX_NODES;
					else
						nodes_raw = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
					fields_raw = $urandom_range(0, 7);
				end
			endcase
			drain();
			set_sizes(nodes_raw, fields_raw);
			repeat ($urandom_range(1, 3))
				run_element(eff_nodes(nodes_raw), eff_fields(fields_raw));
			phase++;
		end

		drain();
		$display("Sent %0d command beats and checked %0d results over %0d register settings",
			beats_sent, results_seen, settings_used);
		if (errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timed out waiting for the block");
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: files.f
rtl/dgvd_pkg.sv
rtl/dgvd_ram.sv
rtl/dgvd_datapath.sv
rtl/dg_volume_divergence_term.sv
tb/dgvd_checker.sv
tb/testbench.sv
